// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// condition that must never hold
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

// ===== rtl/isb_pkg.sv =====
// package for the integer scale pixel blitter: types, constants, defaults
package isb_pkg;

    localparam int ADDR_W      = 16;
    localparam int COLOR_W     = 15;
    localparam int SRC_W       = 8;
    localparam int PIXEL_W     = 32;
    localparam int SCALE_W     = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 160;
    localparam int MAX_SCALE_DEF     = 8;

    localparam logic [SRC_W-1:0] SOURCE_WIDTH_RST  = 8'd240;
    localparam logic [SRC_W-1:0] SOURCE_HEIGHT_RST = 8'd160;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_DIRECT_MODE   = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE_W,
        ST_SCALE_H,
        ST_SCALE_CHK,
        ST_BASE_X,
        ST_BASE_Y,
        ST_BASE_A,
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_rgba;
    } pixel_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  frame_index;
        logic [COLOR_W-1:0] color_bgr555;
        logic               last_of_pixel;
        logic               last_of_frame;
    } write_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
    } cfg_t;

endpackage

// ===== rtl/isb_stream_if.sv =====
// valid/ready channel carrying one payload per transfer
interface isb_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/integer_scale_pixel_blitter_top.sv =====
// top level of the integer scale pixel blitter
// Each accepted source pixel (raster order, packed RGBA8) becomes scale x scale writes of its
// BGR555 color into a SCREEN_WIDTH x SCREEN_HEIGHT frame store, centered, one write per cycle
// while frame_write is ready; in direct mode it makes no writes. The states BASE_X, BASE_Y and
// BASE_A drive the shared multiply-add unit and LOAD takes its result as the start address,
// then the write loop runs. At the first pixel of a frame the scale is found by trying
// candidates from MAX_SCALE downward on the same unit, through SCALE_W, SCALE_H and SCALE_CHK
// for each, which also yields the centering offsets; in direct mode nothing but this search runs.
// The pixel channel is not ready while a pixel is in work; cfg is always ready and is meant to
// be written only while the block is idle.
module integer_scale_pixel_blitter_top #(
    parameter int SCREEN_WIDTH  = isb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = isb_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_SCALE     = isb_pkg::MAX_SCALE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    isb_stream_if.sink   pixel,
    isb_stream_if.source frame_write,
    isb_stream_if.sink   cfg
);
    localparam int DIM_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int DIM_W   = $clog2(DIM_MAX + 1);
    localparam int AW      = isb_pkg::ADDR_W;
    localparam int SW      = isb_pkg::SCALE_W;
    localparam int PW      = isb_pkg::SRC_W;

    localparam logic [AW-1:0] SCREEN_W_A = AW'(SCREEN_WIDTH);
    localparam logic [AW-1:0] SCREEN_H_A = AW'(SCREEN_HEIGHT);
    localparam logic [SW-1:0] SCALE_TOP  = SW'(MAX_SCALE);
    localparam logic [SW-1:0] SCALE_ONE  = SW'(1);
    localparam logic [PW-1:0] POS_ONE    = PW'(1);

    isb_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [isb_pkg::SRC_W-1:0] src_w_reg, src_h_reg;
    logic                      direct_reg;

    // raster position and per-frame geometry
    logic [isb_pkg::SRC_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [SW-1:0]             scale_reg, scale_next, cand_reg, cand_next;
    logic [DIM_W-1:0]          ox_reg, ox_next, oy_reg, oy_next;

    // per-pixel work registers
    logic [isb_pkg::SRC_W-1:0]   col_eff_reg, col_eff_next, row_eff_reg, row_eff_next;
    logic [isb_pkg::COLOR_W-1:0] color_reg, color_next;
    logic                        last_frame_reg, last_frame_next;
    logic                        run_direct_reg, run_direct_next;
    logic [AW-1:0]               wprod_reg, wprod_next;
    logic [AW-1:0]               bx_reg, bx_next;
    logic [AW-1:0]               addr_reg, addr_next;
    logic [SW-1:0]               dx_reg, dx_next, dy_reg, dy_next;

    // shared unit operands
    logic [AW-1:0]    mac_a, mac_c, mac_result;
    logic [DIM_W-1:0] mac_b;

    // effective dimensions and position
    logic [AW-1:0] w_ext, h_ext, w_eff, h_eff;
    logic [AW-1:0] col_ext, row_ext;
    logic [isb_pkg::SRC_W-1:0] col_now, row_now;
    logic          last_col, last_row, frame_start;
    logic          scale_ok;
    logic [AW-1:0] ox_full, oy_full;
    logic          pix_last_col, pix_last_row;
    logic [isb_pkg::PIXEL_W-1:0] rgba;

    // clamp source dimensions to 1..screen size
    always_comb
    begin
        w_ext = AW'(src_w_reg);
        h_ext = AW'(src_h_reg);
        if (w_ext == '0)
            w_eff = AW'(1);
        else if (w_ext > SCREEN_W_A)
            w_eff = SCREEN_W_A;
        else
            w_eff = w_ext;
        if (h_ext == '0)
            h_eff = AW'(1);
        else if (h_ext > SCREEN_H_A)
            h_eff = SCREEN_H_A;
        else
            h_eff = h_ext;
    end

    // wrap the stored position against the current dimensions
    always_comb
    begin
        col_now     = (AW'(col_reg) >= w_eff) ? '0 : col_reg;
        row_now     = (AW'(row_reg) >= h_eff) ? '0 : row_reg;
        col_ext     = AW'(col_now);
        row_ext     = AW'(row_now);
        last_col    = (col_ext + AW'(1)) >= w_eff;
        last_row    = (row_ext + AW'(1)) >= h_eff;
        frame_start = (col_now == '0) && (row_now == '0);
    end

    // scale candidate check and centering offsets
    always_comb
    begin
        scale_ok = (wprod_reg <= SCREEN_W_A) && (mac_result <= SCREEN_H_A);
        ox_full  = (SCREEN_W_A - wprod_reg) >> 1;
        oy_full  = (SCREEN_H_A - mac_result) >> 1;
    end

    // write loop position
    always_comb
    begin
        pix_last_col = (dx_reg == (scale_reg - SCALE_ONE));
        pix_last_row = (dy_reg == (scale_reg - SCALE_ONE));
    end

    assign rgba = pixel.data.pixel_rgba;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= isb_pkg::SOURCE_WIDTH_RST;
            src_h_reg  <= isb_pkg::SOURCE_HEIGHT_RST;
            direct_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.data.index)
                isb_pkg::CFG_SOURCE_WIDTH:  src_w_reg  <= cfg.data.value;
                isb_pkg::CFG_SOURCE_HEIGHT: src_h_reg  <= cfg.data.value;
                isb_pkg::CFG_DIRECT_MODE:   direct_reg <= cfg.data.value[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // sequencer: next state, unit operands and register updates
    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        scale_next      = scale_reg;
        cand_next       = cand_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        col_eff_next    = col_eff_reg;
        row_eff_next    = row_eff_reg;
        color_next      = color_reg;
        last_frame_next = last_frame_reg;
        run_direct_next = run_direct_reg;
        wprod_next      = wprod_reg;
        bx_next         = bx_reg;
        addr_next       = addr_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        mac_a           = mac_result;
        mac_b           = DIM_W'(SCREEN_WIDTH);
        mac_c           = '0;

        unique case (state_reg)
            isb_pkg::ST_IDLE:
            begin
                if (pixel.valid)
                begin
                    color_next      = {rgba[23:19], rgba[15:11], rgba[7:3]};
                    col_eff_next    = col_now;
                    row_eff_next    = row_now;
                    last_frame_next = last_col && last_row;
                    run_direct_next = direct_reg;
                    cand_next       = SCALE_TOP;
                    // advance the raster position
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = last_row ? '0 : row_now + POS_ONE;
                    end
                    else
                    begin
                        col_next = col_now + POS_ONE;
                        row_next = row_now;
                    end
                    priority if (frame_start)
                        state_next = isb_pkg::ST_SCALE_W;
                    else if (direct_reg)
                        state_next = isb_pkg::ST_IDLE;
                    else
                        state_next = isb_pkg::ST_BASE_X;
                end
            end

            isb_pkg::ST_SCALE_W:
            begin
                mac_a      = w_eff;
                mac_b      = DIM_W'(cand_reg);
                state_next = isb_pkg::ST_SCALE_H;
            end

            isb_pkg::ST_SCALE_H:
            begin
                wprod_next = mac_result;
                mac_a      = h_eff;
                mac_b      = DIM_W'(cand_reg);
                state_next = isb_pkg::ST_SCALE_CHK;
            end

            isb_pkg::ST_SCALE_CHK:
            begin
                // a candidate of one always fits
                if (scale_ok || (cand_reg == SCALE_ONE))
                begin
                    scale_next = cand_reg;
                    ox_next    = DIM_W'(ox_full);
                    oy_next    = DIM_W'(oy_full);
                    state_next = run_direct_reg ? isb_pkg::ST_IDLE : isb_pkg::ST_BASE_X;
                end
                else
                begin
                    cand_next  = cand_reg - SCALE_ONE;
                    state_next = isb_pkg::ST_SCALE_W;
                end
            end

            isb_pkg::ST_BASE_X:
            begin
                mac_a      = AW'(col_eff_reg);
                mac_b      = DIM_W'(scale_reg);
                mac_c      = AW'(ox_reg);
                state_next = isb_pkg::ST_BASE_Y;
            end

            isb_pkg::ST_BASE_Y:
            begin
                bx_next    = mac_result;
                mac_a      = AW'(row_eff_reg);
                mac_b      = DIM_W'(scale_reg);
                mac_c      = AW'(oy_reg);
                state_next = isb_pkg::ST_BASE_A;
            end

            isb_pkg::ST_BASE_A:
            begin
                mac_a      = mac_result;
                mac_b      = DIM_W'(SCREEN_WIDTH);
                mac_c      = bx_reg;
                state_next = isb_pkg::ST_LOAD;
            end

            isb_pkg::ST_LOAD:
            begin
                addr_next  = mac_result;
                dx_next    = '0;
                dy_next    = '0;
                state_next = isb_pkg::ST_EMIT;
            end

            isb_pkg::ST_EMIT:
            begin
                if (frame_write.ready)
                begin
                    priority if (pix_last_col && pix_last_row)
                        state_next = isb_pkg::ST_IDLE;
                    else if (pix_last_col)
                    begin
                        // step to the start of the next destination row
                        dx_next   = '0;
                        dy_next   = dy_reg + SCALE_ONE;
                        addr_next = addr_reg + SCREEN_W_A + AW'(1) - AW'(scale_reg);
                    end
                    else
                    begin
                        dx_next   = dx_reg + SCALE_ONE;
                        addr_next = addr_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = isb_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= isb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            scale_reg      <= SCALE_ONE;
            cand_reg       <= SCALE_TOP;
            ox_reg         <= '0;
            oy_reg         <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            run_direct_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            scale_reg      <= scale_next;
            cand_reg       <= cand_next;
            ox_reg         <= ox_next;
            oy_reg         <= oy_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            run_direct_reg <= run_direct_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        col_eff_reg    <= col_eff_next;
        row_eff_reg    <= row_eff_next;
        color_reg      <= color_next;
        last_frame_reg <= last_frame_next;
        wprod_reg      <= wprod_next;
        bx_reg         <= bx_next;
        addr_reg       <= addr_next;
    end

    isb_mac #(
        .B_W (DIM_W)
    ) u_mac (
        .clk    (clk),
        .a      (mac_a),
        .b      (mac_b),
        .c      (mac_c),
        .result (mac_result)
    );

    // channel outputs
    assign pixel.ready                  = (state_reg == isb_pkg::ST_IDLE);
    assign frame_write.valid            = (state_reg == isb_pkg::ST_EMIT);
    assign frame_write.data.frame_index = addr_reg;
    assign frame_write.data.color_bgr555 = color_reg;
    assign frame_write.data.last_of_pixel = pix_last_col && pix_last_row;
    assign frame_write.data.last_of_frame = pix_last_col && pix_last_row && last_frame_reg;
endmodule

// ===== rtl/isb_mac.sv =====
// shared multiply-add unit: result = low bits of a * b + c, registered
module isb_mac #(
    parameter int B_W = 11
) (
    input  logic                       clk,
    input  logic [isb_pkg::ADDR_W-1:0] a,
    input  logic [B_W-1:0]             b,
    input  logic [isb_pkg::ADDR_W-1:0] c,
    output logic [isb_pkg::ADDR_W-1:0] result
);
    localparam int PROD_W = isb_pkg::ADDR_W + B_W;

    logic [PROD_W-1:0]          prod;
    logic [isb_pkg::ADDR_W-1:0] result_reg;
    logic [isb_pkg::ADDR_W-1:0] result_next;

    // product kept to the address width, then offset added
    always_comb
    begin
        prod        = PROD_W'(a) * PROD_W'(b);
        result_next = prod[isb_pkg::ADDR_W-1:0] + c;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
endmodule

// ===== rtl/isb_checker.sv =====
// port-level checker for the integer scale pixel blitter, bound to the top level
`include "assert_macros.svh"

module isb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [isb_pkg::ADDR_W-1:0]  frame_index,
    input logic [isb_pkg::COLOR_W-1:0] color_bgr555,
    input logic                        last_of_pixel,
    input logic                        last_of_frame
);
    logic out_transfer;
    logic [isb_pkg::ADDR_W+isb_pkg::COLOR_W+1:0] payload;

    assign out_transfer = out_valid && out_ready;
    assign payload      = {frame_index, color_bgr555, last_of_pixel, last_of_frame};

    // a stalled write holds its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(payload))

    // no new pixel is taken while writes are pending
    `ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid)

    // end of frame only on the end of a pixel
    `ASSERT_IMPLIES(a_frame_end, clk, rst_n, out_valid && last_of_frame, last_of_pixel)

    // after the last write of a pixel the block is ready again
    `ASSERT_NEXT(a_pixel_done, clk, rst_n, out_transfer && last_of_pixel, in_ready && !out_valid)
endmodule

bind integer_scale_pixel_blitter_top isb_checker u_isb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (pixel.ready),
    .out_valid     (frame_write.valid),
    .out_ready     (frame_write.ready),
    .frame_index   (frame_write.data.frame_index),
    .color_bgr555  (frame_write.data.color_bgr555),
    .last_of_pixel (frame_write.data.last_of_pixel),
    .last_of_frame (frame_write.data.last_of_frame)
);
